// File: rtl/core/exponential_rms_meter_assert.svh
// ----------------------------------------------------------------------------
// exponential_rms_meter_assert.svh
// assertion macros used by the rms meter rtl
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_RMS_METER_ASSERT_SVH
`define EXPONENTIAL_RMS_METER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ERM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ERM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg
// types and constants of the exponential rms meter
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int ALPHA_W    = 17;
    localparam int MS_W       = 32;
    localparam int RMS_W      = 16;
    localparam int PROD_W     = ALPHA_W + MS_W;
    localparam int ROOT_STEPS = RMS_W;
    localparam int STEP_CNT_W = $clog2(ROOT_STEPS);

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd656;
    localparam logic [MS_W-1:0]    MS_MAX      = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_MUL_NEW,
        S_MUL_OLD,
        S_SUM,
        S_ROOT,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic load;      // capture sample magnitude
        logic square;    // magnitude squared
        logic mul_new;   // alpha * square
        logic mul_old;   // (one - alpha) * mean square
        logic sum;       // new mean square, seed root
        logic root_step; // one root bit
        logic out_load;  // root into output register
    } t_dp_cmd;

endpackage

// File: rtl/core/erm_ctrl.sv
// ----------------------------------------------------------------------------
// erm_ctrl
// sequencer of the rms meter: one item at a time through the datapath
// ----------------------------------------------------------------------------
module erm_ctrl
    import erm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_sample_valid,
    output logic    o_sample_ready,
    output logic    o_rms_valid,
    input  logic    i_rms_ready,
    output t_dp_cmd o_cmd
);

    t_state                r_state, n_state;
    logic [STEP_CNT_W-1:0] r_step, n_step;
    logic                  r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        o_cmd          = '0;
        o_sample_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_sample_ready = 1'b1;
                if (i_sample_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_MUL_NEW;
            end
            S_MUL_NEW: begin
                o_cmd.mul_new = 1'b1;
                n_state       = S_MUL_OLD;
            end
            S_MUL_OLD: begin
                o_cmd.mul_old = 1'b1;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_step    = '0;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == STEP_CNT_W'(ROOT_STEPS - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                // wait for the output register to be free
                if (!r_out_valid || i_rms_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load | (r_out_valid & ~i_rms_ready);
    end

    assign o_rms_valid = r_out_valid;

endmodule

// File: rtl/core/erm_dp.sv
// ----------------------------------------------------------------------------
// erm_dp
// datapath of the rms meter: square, shared multiplier, mean square, root
// ----------------------------------------------------------------------------
module erm_dp
    import erm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_cfg_we,
    input  logic [ALPHA_W-1:0]            i_cfg_data,
    output logic [RMS_W-1:0]              o_rms
);

    localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
    localparam int FRAC  = 2 * SAMPLE_BITS - 2;
    localparam int EXT_W = SQ_W + MS_W;

    logic [ALPHA_W-1:0]     r_alpha;
    logic [MS_W-1:0]        r_ms;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [SQ_W-1:0]        r_sq;
    logic [PROD_W-1:0]      r_prod_new;
    logic [PROD_W-1:0]      r_prod_old;
    logic [MS_W-1:0]        r_rad;
    logic [RMS_W-1:0]       r_root;
    logic [RMS_W:0]         r_rem;
    logic [RMS_W-1:0]       r_rms;

    logic [SAMPLE_BITS-1:0] w_mag;
    logic [ALPHA_W-1:0]     w_alpha_eff;
    logic [EXT_W-1:0]       w_ext;
    logic [MS_W-1:0]        w_sq32;
    logic [ALPHA_W-1:0]     w_mul_a;
    logic [MS_W-1:0]        w_mul_b;
    logic [PROD_W-1:0]      w_prod;
    logic [PROD_W:0]        w_sum;
    logic [MS_W-1:0]        w_ms_next;
    logic [RMS_W+2:0]       w_rem_t;
    logic [RMS_W+2:0]       w_trial;
    logic [RMS_W+2:0]       w_diff;

    // magnitude of the two's complement sample, most negative gives 2^(n-1)
    assign w_mag = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;

    // alpha above one acts as one
    assign w_alpha_eff = r_alpha[ALPHA_W-1] ? ALPHA_ONE : r_alpha;

    // square to q0.32, saturating at full scale
    assign w_ext  = {r_sq, {MS_W{1'b0}}} >> FRAC;
    assign w_sq32 = (|w_ext[EXT_W-1:MS_W]) ? MS_MAX : w_ext[MS_W-1:0];

    // one multiplier shared by both weighted terms
    assign w_mul_a = i_cmd.mul_new ? w_alpha_eff : (ALPHA_ONE - w_alpha_eff);
    assign w_mul_b = i_cmd.mul_new ? w_sq32 : r_ms;
    assign w_prod  = w_mul_a * w_mul_b;

    assign w_sum     = {1'b0, r_prod_new} + {1'b0, r_prod_old};
    assign w_ms_next = (|w_sum[PROD_W:MS_W+16]) ? MS_MAX : w_sum[MS_W+15:16];

    // restoring square root, one result bit a step
    assign w_rem_t = {r_rem, r_rad[MS_W-1:MS_W-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_diff  = w_rem_t - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_ms    <= '0;
        end else if (i_cfg_we) begin
            r_alpha <= i_cfg_data;
            r_ms    <= '0;
        end else if (i_cmd.sum) begin
            r_ms <= w_ms_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= w_mag;
        end
        if (i_cmd.square) begin
            r_sq <= SQ_W'(r_mag) * SQ_W'(r_mag);
        end
        if (i_cmd.mul_new) begin
            r_prod_new <= w_prod;
        end
        if (i_cmd.mul_old) begin
            r_prod_old <= w_prod;
        end
        if (i_cmd.sum) begin
            r_rad  <= w_ms_next;
            r_root <= '0;
            r_rem  <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[MS_W-3:0], 2'b00};
            if (w_rem_t >= w_trial) begin
                r_rem  <= w_diff[RMS_W:0];
                r_root <= {r_root[RMS_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_t[RMS_W:0];
                r_root <= {r_root[RMS_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_rms <= r_root;
        end
    end

    assign o_rms = r_rms;

endmodule

// File: rtl/core/exponential_rms_meter.sv
// ----------------------------------------------------------------------------
// exponential_rms_meter
// running rms of a signed sample stream with exponential smoothing
// ----------------------------------------------------------------------------
// each accepted item is one signed q1.(n-1) sample; it is squared to q0.32,
// folded into the mean square as ((1 - alpha) * ms + alpha * sq) >> 16 and
// the floor square root of the new mean square leaves as a q0.16 rms item.
// alpha is q1.16 (reset 656, values above one act as one); writing it clears
// the mean square. one item is in flight at a time and passes, from the
// accepting cycle to the load of the result register, through these steps:
// accept, square, two passes through the shared 17x32 multiplier, the mean
// square update, the bit-serial square root and the load of the output
// register. the output register lets the result wait for the consumer while
// the next item is taken; if it is still waiting when the next result is
// ready, input stalls until it goes.
// ----------------------------------------------------------------------------
module exponential_rms_meter
    import erm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // rms channel
    output logic                          o_rms_valid,
    input  logic                          i_rms_ready,
    output logic [RMS_W-1:0]              o_rms,
    // alpha register write
    input  logic                          i_cfg_we,
    input  logic [ALPHA_W-1:0]            i_cfg_data
);

`include "exponential_rms_meter_assert.svh"

    // command bundle from sequencer to datapath
    t_dp_cmd w_cmd;

    erm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .o_rms_valid    (o_rms_valid),
        .i_rms_ready    (i_rms_ready),
        .o_cmd          (w_cmd)
    );

    erm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_sample   (i_sample),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_rms      (o_rms)
    );

    // an accepted item keeps the block busy on the next cycle
    `ERM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_sample_valid && o_sample_ready, !o_sample_ready, "ready after accept")

    // a result is only loaded when the output register is free or being taken
    `ERM_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n,
        w_cmd.out_load && o_rms_valid, i_rms_ready, "result overwritten")

    // a loaded result is presented on the next cycle
    `ERM_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n,
        w_cmd.out_load, o_rms_valid, "loaded result not valid")

endmodule
